// ===== rtl/pnn_pkg.sv =====
`timescale 1ns / 1ps

package pnn_pkg;

  localparam int COORD_W   = 16;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int NUM_LANES = 3;

  // Aligned magnitudes, their sum of squares, its root and the quotient.
  localparam int A_W    = 30;
  localparam int SQ_W   = 2 * A_W + 2;
  localparam int ROOT_W = SQ_W / 2;
  localparam int FRAC_W = 14;
  localparam int Q_W    = FRAC_W + 1;
  localparam int NUM_W  = A_W + FRAC_W + 1;

  localparam int NORM_W   = 16;
  localparam int STATUS_W = 2;

  localparam int DEF_MAX_POLY_VERTICES = 256;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVER = 2'd2;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctrl_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
  } norm_res_t;

endpackage

// ===== rtl/pnn_edge_mac.sv =====
`timescale 1ns / 1ps

module pnn_edge_mac #(
  parameter int SUM_W = pnn_pkg::PROD_W + $clog2(pnn_pkg::DEF_MAX_POLY_VERTICES)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pnn_pkg::mac_ctrl_t                ctrl,
  input  logic signed [pnn_pkg::COORD_W-1:0] cur [pnn_pkg::NUM_LANES],
  input  logic signed [pnn_pkg::COORD_W-1:0] nxt [pnn_pkg::NUM_LANES],
  output logic                              busy,
  output logic signed [SUM_W-1:0]           sum [pnn_pkg::NUM_LANES]
);

  localparam int EW    = pnn_pkg::EDGE_W;
  localparam int CNT_W = $clog2(EW);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_STEP = 2'd1;
  localparam logic [1:0] M_ACC  = 2'd2;

  logic [1:0]       mstate;
  logic [CNT_W-1:0] cnt;
  logic             last_bit;

  assign busy     = (mstate != M_IDLE);
  assign last_bit = (cnt == CNT_W'(EW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= M_IDLE;
      cnt    <= '0;
    end else begin
      unique case (mstate)
        M_IDLE: begin
          if (ctrl.start) begin
            cnt    <= '0;
            mstate <= M_STEP;
          end
        end
        M_STEP: begin
          cnt <= cnt + CNT_W'(1);
          if (last_bit) begin
            mstate <= M_ACC;
          end
        end
        M_ACC: begin
          mstate <= M_IDLE;
        end
        default: begin
          mstate <= M_IDLE;
        end
      endcase
    end
  end

  // Each lane multiplies a coordinate difference by a coordinate sum, one
  // multiplier bit per cycle, and the sign bit's weight is subtracted.
  for (genvar g = 0; g < pnn_pkg::NUM_LANES; g++) begin : g_lane
    localparam int DI = (g + 1) % pnn_pkg::NUM_LANES;
    localparam int SI = (g + 2) % pnn_pkg::NUM_LANES;

    logic signed [EW-1:0] d_in;
    logic signed [EW-1:0] s_in;
    logic signed [EW-1:0] mcnd;
    logic signed [EW:0]   h;
    logic [EW-1:0]        l;
    logic signed [EW:0]   ext;
    logic signed [EW:0]   addend;
    logic signed [EW:0]   hs;

    always_comb begin
      d_in = {cur[DI][pnn_pkg::COORD_W-1], cur[DI]} - {nxt[DI][pnn_pkg::COORD_W-1], nxt[DI]};
      s_in = {cur[SI][pnn_pkg::COORD_W-1], cur[SI]} + {nxt[SI][pnn_pkg::COORD_W-1], nxt[SI]};
      ext  = {mcnd[EW-1], mcnd};
      if (!l[0]) begin
        addend = '0;
      end else if (last_bit) begin
        addend = -ext;
      end else begin
        addend = ext;
      end
      hs = h + addend;
    end

    always_ff @(posedge clk) begin
      if (mstate == M_IDLE && ctrl.start) begin
        mcnd <= s_in;
        l    <= d_in;
        h    <= '0;
      end else if (mstate == M_STEP) begin
        h <= {hs[EW], hs[EW:1]};
        l <= {hs[0], l[EW-1:1]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sum[g] <= '0;
      end else if (ctrl.clear) begin
        sum[g] <= '0;
      end else if (mstate == M_ACC) begin
        sum[g] <= sum[g] + {{(SUM_W - 2 * EW - 1){h[EW]}}, h, l};
      end
    end
  end

endmodule

// ===== rtl/pnn_norm.sv =====
`timescale 1ns / 1ps

module pnn_norm #(
  parameter int SUM_W = pnn_pkg::PROD_W + $clog2(pnn_pkg::DEF_MAX_POLY_VERTICES)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum [pnn_pkg::NUM_LANES],
  output logic                    busy,
  output pnn_pkg::norm_res_t      res
);

  localparam int AW    = pnn_pkg::A_W;
  localparam int SQW   = pnn_pkg::SQ_W;
  localparam int RW    = pnn_pkg::ROOT_W;
  localparam int QW    = pnn_pkg::Q_W;
  localparam int NW    = pnn_pkg::NUM_W;
  localparam int OW    = pnn_pkg::NORM_W;
  localparam int NL    = pnn_pkg::NUM_LANES;
  localparam int CNT_W = $clog2(RW);

  localparam logic [2:0] N_IDLE     = 3'd0;
  localparam logic [2:0] N_ALIGN    = 3'd1;
  localparam logic [2:0] N_SQ_LOAD  = 3'd2;
  localparam logic [2:0] N_SQ_STEP  = 3'd3;
  localparam logic [2:0] N_SQ_ACC   = 3'd4;
  localparam logic [2:0] N_ROOT     = 3'd5;
  localparam logic [2:0] N_DIV_LOAD = 3'd6;
  localparam logic [2:0] N_DIV_STEP = 3'd7;

  logic [2:0]                          state;
  logic [1:0]                          comp;
  logic [CNT_W-1:0]                    cnt;
  logic [SUM_W-1:0]                    mag [NL];
  logic                                neg [NL];
  logic [AW:0]                         mh;
  logic [AW-1:0]                       ml;
  logic [SQW-1:0]                      sq;
  logic [RW+1:0]                       rem_r;
  logic [RW-1:0]                       root;
  logic [RW-1:0]                       drem;
  logic [QW-1:0]                       nlo;
  logic [QW-1:0]                       quo;
  logic signed [OW-1:0]                outc [NL];
  logic [pnn_pkg::STATUS_W-1:0]        st;

  logic [AW-1:0]        mcand;
  logic [AW:0]          sq_sum;
  logic [RW+3:0]        rt_rem;
  logic [RW+3:0]        rt_trial;
  logic [RW+3:0]        rt_diff;
  logic                 rt_ge;
  logic [NW-1:0]        num;
  logic [RW:0]          dv_t;
  logic [RW:0]          dv_den;
  logic [RW:0]          dv_diff;
  logic                 dv_ge;
  logic [QW-1:0]        qfin;
  logic [OW-1:0]        qv;
  logic signed [OW-1:0] qsigned;
  logic                 all_zero;
  logic                 too_high;
  logic                 too_low;

  assign busy = (state != N_IDLE);
  assign res  = '{status: st, x: outc[0], y: outc[1], z: outc[2]};

  always_comb begin
    all_zero = 1'b1;
    too_high = 1'b0;
    too_low  = 1'b1;
    for (int i = 0; i < NL; i++) begin
      if (mag[i] != '0) begin
        all_zero = 1'b0;
      end
      if (mag[i][SUM_W-1:AW] != '0) begin
        too_high = 1'b1;
      end
      if (mag[i][SUM_W-1:AW-1] != '0) begin
        too_low = 1'b0;
      end
    end

    mcand  = mag[comp][AW-1:0];
    sq_sum = mh + (ml[0] ? {1'b0, mcand} : '0);

    rt_rem   = {rem_r, sq[SQW-1 -: 2]};
    rt_trial = {2'b00, root, 2'b01};
    rt_ge    = (rt_rem >= rt_trial);
    rt_diff  = rt_rem - rt_trial;

    num = {1'b0, mcand, {pnn_pkg::FRAC_W{1'b0}}} + {{(NW - RW + 1){1'b0}}, root[RW-1:1]};

    dv_t    = {drem, nlo[QW-1]};
    dv_den  = {1'b0, root};
    dv_ge   = (dv_t >= dv_den);
    dv_diff = dv_t - dv_den;

    qfin    = {quo[QW-2:0], dv_ge};
    qv      = {{(OW - QW){1'b0}}, qfin};
    qsigned = neg[comp] ? -qv : qv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      comp  <= '0;
      cnt   <= '0;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < NL; i++) begin
              mag[i] <= sum[i][SUM_W-1] ? SUM_W'(-sum[i]) : SUM_W'(sum[i]);
              neg[i] <= sum[i][SUM_W-1];
            end
            state <= N_ALIGN;
          end
        end
        N_ALIGN: begin
          priority if (all_zero) begin
            st <= pnn_pkg::STATUS_ZERO;
            for (int i = 0; i < NL; i++) begin
              outc[i] <= '0;
            end
            state <= N_IDLE;
          end else if (too_high) begin
            for (int i = 0; i < NL; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else if (too_low) begin
            for (int i = 0; i < NL; i++) begin
              mag[i] <= mag[i] << 1;
            end
          end else begin
            comp  <= '0;
            sq    <= '0;
            state <= N_SQ_LOAD;
          end
        end
        N_SQ_LOAD: begin
          ml    <= mcand;
          mh    <= '0;
          cnt   <= '0;
          state <= N_SQ_STEP;
        end
        N_SQ_STEP: begin
          mh  <= {1'b0, sq_sum[AW:1]};
          ml  <= {sq_sum[0], ml[AW-1:1]};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(AW - 1)) begin
            state <= N_SQ_ACC;
          end
        end
        N_SQ_ACC: begin
          sq <= sq + {2'b00, mh[AW-1:0], ml};
          if (comp == 2'(NL - 1)) begin
            rem_r <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= N_ROOT;
          end else begin
            comp  <= comp + 2'd1;
            state <= N_SQ_LOAD;
          end
        end
        N_ROOT: begin
          rem_r <= rt_ge ? rt_diff[RW+1:0] : rt_rem[RW+1:0];
          root  <= {root[RW-2:0], rt_ge};
          sq    <= sq << 2;
          cnt   <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(RW - 1)) begin
            comp  <= '0;
            state <= N_DIV_LOAD;
          end
        end
        N_DIV_LOAD: begin
          drem  <= {1'b0, num[NW-1:QW]};
          nlo   <= num[QW-1:0];
          quo   <= '0;
          cnt   <= '0;
          state <= N_DIV_STEP;
        end
        N_DIV_STEP: begin
          drem <= dv_ge ? dv_diff[RW-1:0] : dv_t[RW-1:0];
          nlo  <= nlo << 1;
          quo  <= qfin;
          cnt  <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(QW - 1)) begin
            outc[comp] <= qsigned;
            if (comp == 2'(NL - 1)) begin
              st    <= pnn_pkg::STATUS_OK;
              state <= N_IDLE;
            end else begin
              comp  <= comp + 2'd1;
              state <= N_DIV_LOAD;
            end
          end
        end
        default: begin
          state <= N_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/polygon_normal_newell.sv =====
`timescale 1ns / 1ps

// Polygon normal by Newell's method.
// Vertices arrive on the vert channel (vert_valid, vert_ready), one per
// transaction, as signed Q8.8 coordinates; last_vertex marks the final one.
// Each polygon gives one transaction on the norm channel (norm_valid,
// norm_ready): a unit normal in signed Q1.14 and a status code (ok, zero
// length, or more than MAX_POLY_VERTICES vertices, both of which give zero).
// Every vertex after the first, up to the MAX_POLY_VERTICES-th, runs one edge
// through the bit-serial edge multiplier, one step per multiplier bit and then
// an accumulate step; no new vertex is taken until that edge is done. The
// last vertex adds the closing edge and then starts the normalizer, which
// aligns the sums one bit per cycle, squares them one multiplier bit per
// cycle, takes the square root two radicand bits per cycle and divides one
// quotient bit per cycle. All-zero sums give their result straight from the
// alignment step, and a polygon with too many vertices skips the closing edge
// and the normalizer.
// The result sits in an output register; the next polygon's vertices are
// taken while it waits, and only a second finished result waits on the
// receiver. Reset clears the sums, the vertex count and both channels.
module polygon_normal_newell #(
  parameter int MAX_POLY_VERTICES = pnn_pkg::DEF_MAX_POLY_VERTICES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               vert_valid,
  output logic                               vert_ready,
  input  logic signed [pnn_pkg::COORD_W-1:0]  vert_x,
  input  logic signed [pnn_pkg::COORD_W-1:0]  vert_y,
  input  logic signed [pnn_pkg::COORD_W-1:0]  vert_z,
  input  logic                               last_vertex,
  output logic                               norm_valid,
  input  logic                               norm_ready,
  output logic signed [pnn_pkg::NORM_W-1:0]   norm_x,
  output logic signed [pnn_pkg::NORM_W-1:0]   norm_y,
  output logic signed [pnn_pkg::NORM_W-1:0]   norm_z,
  output logic [pnn_pkg::STATUS_W-1:0]        status
);

  localparam int CNT_W = $clog2(MAX_POLY_VERTICES + 2);
  localparam int SUM_W = pnn_pkg::PROD_W + $clog2(MAX_POLY_VERTICES);
  localparam int NL    = pnn_pkg::NUM_LANES;

  localparam logic [2:0] S_IDLE        = 3'd0;
  localparam logic [2:0] S_EDGE        = 3'd1;
  localparam logic [2:0] S_START_CLOSE = 3'd2;
  localparam logic [2:0] S_CLOSE       = 3'd3;
  localparam logic [2:0] S_NORM        = 3'd4;
  localparam logic [2:0] S_EMIT        = 3'd5;

  logic [2:0]                         state;
  logic [CNT_W-1:0]                   count;
  logic                               last_q;
  logic                               over_q;
  logic signed [pnn_pkg::COORD_W-1:0] vin     [NL];
  logic signed [pnn_pkg::COORD_W-1:0] prev_v  [NL];
  logic signed [pnn_pkg::COORD_W-1:0] first_v [NL];
  logic signed [pnn_pkg::COORD_W-1:0] nxt_v   [NL];
  logic signed [SUM_W-1:0]            sums    [NL];

  pnn_pkg::mac_ctrl_t mac_ctrl;
  pnn_pkg::norm_res_t norm_res;
  logic               mac_busy;
  logic               norm_busy;
  logic               norm_start;
  logic               accept;
  logic               need_edge;
  logic               over_now;
  logic               emit;

  assign vin[0] = vert_x;
  assign vin[1] = vert_y;
  assign vin[2] = vert_z;

  assign vert_ready = (state == S_IDLE);
  assign accept     = vert_valid && vert_ready;
  assign need_edge  = (count != '0) && (count < CNT_W'(MAX_POLY_VERTICES));
  assign over_now   = (count >= CNT_W'(MAX_POLY_VERTICES));
  assign emit       = (state == S_EMIT) && (!norm_valid || norm_ready);
  assign norm_start = (state == S_CLOSE) && !mac_busy;

  assign mac_ctrl.start = (accept && need_edge) || (state == S_START_CLOSE);
  assign mac_ctrl.clear = emit;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      nxt_v[i] = (state == S_IDLE) ? vin[i] : first_v[i];
    end
  end

  pnn_edge_mac #(
    .SUM_W(SUM_W)
  ) u_mac (
    .clk (clk),
    .rst (rst),
    .ctrl(mac_ctrl),
    .cur (prev_v),
    .nxt (nxt_v),
    .busy(mac_busy),
    .sum (sums)
  );

  pnn_norm #(
    .SUM_W(SUM_W)
  ) u_norm (
    .clk  (clk),
    .rst  (rst),
    .start(norm_start),
    .sum  (sums),
    .busy (norm_busy),
    .res  (norm_res)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NL; i++) begin
        prev_v[i] <= vin[i];
        if (count == '0) begin
          first_v[i] <= vin[i];
        end
      end
      last_q <= last_vertex;
      over_q <= over_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (count <= CNT_W'(MAX_POLY_VERTICES)) begin
              count <= count + CNT_W'(1);
            end
            priority if (need_edge) begin
              state <= S_EDGE;
            end else if (last_vertex) begin
              state <= over_now ? S_EMIT : S_START_CLOSE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EDGE: begin
          if (!mac_busy) begin
            priority if (!last_q) begin
              state <= S_IDLE;
            end else if (over_q) begin
              state <= S_EMIT;
            end else begin
              state <= S_START_CLOSE;
            end
          end
        end
        S_START_CLOSE: begin
          state <= S_CLOSE;
        end
        S_CLOSE: begin
          if (!mac_busy) begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (!norm_busy) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            count <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_valid <= 1'b0;
    end else if (emit) begin
      norm_valid <= 1'b1;
    end else if (norm_ready) begin
      norm_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (over_q) begin
        norm_x <= '0;
        norm_y <= '0;
        norm_z <= '0;
        status <= pnn_pkg::STATUS_OVER;
      end else begin
        norm_x <= norm_res.x;
        norm_y <= norm_res.y;
        norm_z <= norm_res.z;
        status <= norm_res.status;
      end
    end
  end

  a_mac_start_free: assert property (@(posedge clk) disable iff (rst)
    mac_ctrl.start |-> !mac_busy && !norm_busy)
    else $error("edge multiplier started while a unit is busy");

  a_norm_start_free: assert property (@(posedge clk) disable iff (rst)
    norm_start |-> !norm_busy && !mac_ctrl.start)
    else $error("normalizer started while busy");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mac_busy && !norm_busy)
    else $error("vertex offered while a unit is still working");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POLY_VERTICES + 1))
    else $error("vertex count passed its saturation value");

  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    emit |=> (sums[0] == '0) && (sums[1] == '0) && (sums[2] == '0))
    else $error("edge sums not cleared after a result");

endmodule
